@@ design/vmt_pkg.sv @@
// Shared types, widths and constants for the vertex matrix transform core.
// No dependencies; every other design file refers to it by scoped names.
package vmt_pkg;

  localparam int unsigned COMP_W    = 16;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned REG_W     = COMP_W * NUM_LANES;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COEF_FRAC = 12;

  localparam int unsigned PROD_W = 2 * COMP_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef comp_t [NUM_LANES-1:0]    quad_t;
  typedef quad_t [NUM_LANES-1:0]    coef_mat_t;
  typedef logic [REG_W-1:0]         row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ZERO    = 3'd0,
    CFG_ROW_ONE     = 3'd1,
    CFG_ROW_TWO     = 3'd2,
    CFG_ROW_THREE   = 3'd3,
    CFG_COLUMN_MODE = 3'd4
  } cfg_idx_e;

  localparam row_t ROW_ZERO_RST  = 64'h0000_0000_0000_1000;
  localparam row_t ROW_ONE_RST   = 64'h0000_0000_1000_0000;
  localparam row_t ROW_TWO_RST   = 64'h0000_1000_0000_0000;
  localparam row_t ROW_THREE_RST = 64'h1000_0000_0000_0000;

  localparam sum_t ROUND_BIAS   = SUM_W'((64'd1 << COEF_FRAC) >> 1);
  localparam sum_t SUM_LANE_MAX = SUM_W'((2 ** (COMP_W - 1)) - 1);
  localparam sum_t SUM_LANE_MIN = SUM_W'(-(2 ** (COMP_W - 1)));

endpackage

@@ design/vmt_vertex_if.sv @@
// Valid/ready channel interfaces for vertex input and transformed result.
// Depends on vmt_pkg for component types.
interface vmt_vertex_if;
  logic          valid;
  logic          ready;
  vmt_pkg::comp_t in_x;
  vmt_pkg::comp_t in_y;
  vmt_pkg::comp_t in_z;
  vmt_pkg::comp_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

interface vmt_result_if;
  logic          valid;
  logic          ready;
  vmt_pkg::comp_t out_x;
  vmt_pkg::comp_t out_y;
  vmt_pkg::comp_t out_z;
  vmt_pkg::comp_t out_w;
  logic          saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

@@ design/vertex_matrix_transform_core.sv @@
// Top level of the 4x4 fixed-point homogeneous vertex transform.
// Depends on vmt_pkg, vmt_vertex_if, vmt_result_if, vmt_cfg_regs and vmt_lane.
//
//   channel   direction  transaction
//   vertex_i  in         one vertex in_x, in_y, in_z, in_w
//   result_o  out        out_x, out_y, out_z, out_w, saturated
//   cfg_*     in         one register write per cycle with cfg_we_i high
//
// An accepted vertex passes the multiply, sum-and-round and saturate stage
// registers to a valid result; one vertex enters per cycle unless result_o stalls.
// Reset clears stage valid bits and loads the identity matrix, row mode.
// A stalled result holds the whole pipeline; vertex_i.ready drops with it.
module vertex_matrix_transform_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  vmt_vertex_if.sink                    vertex_i,
  vmt_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [vmt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  vmt_pkg::row_t                 cfg_data_i
);

  vmt_pkg::coef_mat_t lane_coef;
  vmt_pkg::quad_t     vtx;
  vmt_pkg::quad_t     lane_res;
  logic [vmt_pkg::NUM_LANES-1:0] lane_sat;
  logic [2:0]         valid_q, valid_d;
  logic               advance;

  assign advance = !valid_q[2] || result_o.ready;
  assign vertex_i.ready = advance;

  assign vtx[0] = vertex_i.in_x;
  assign vtx[1] = vertex_i.in_y;
  assign vtx[2] = vertex_i.in_z;
  assign vtx[3] = vertex_i.in_w;

  assign valid_d = {valid_q[1:0], vertex_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  vmt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .lane_coef_o (lane_coef)
  );

  for (genvar l = 0; l < vmt_pkg::NUM_LANES; l++) begin : g_lane
    vmt_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (advance),
      .vtx_i  (vtx),
      .coef_i (lane_coef[l]),
      .res_o  (lane_res[l]),
      .sat_o  (lane_sat[l])
    );
  end

  assign result_o.valid     = valid_q[2];
  assign result_o.out_x     = lane_res[0];
  assign result_o.out_y     = lane_res[1];
  assign result_o.out_z     = lane_res[2];
  assign result_o.out_w     = lane_res[3];
  assign result_o.saturated = |lane_sat;

endmodule

@@ design/vmt_cfg_regs.sv @@
// Matrix row and mode registers with per-lane coefficient selection.
// Depends on vmt_pkg.
module vmt_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  vmt_pkg::row_t                  cfg_data_i,
  output vmt_pkg::coef_mat_t             lane_coef_o
);

  vmt_pkg::row_t rows_q [vmt_pkg::NUM_LANES];
  logic          mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= vmt_pkg::ROW_ZERO_RST;
      rows_q[1] <= vmt_pkg::ROW_ONE_RST;
      rows_q[2] <= vmt_pkg::ROW_TWO_RST;
      rows_q[3] <= vmt_pkg::ROW_THREE_RST;
      mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vmt_pkg::CFG_ROW_ZERO:    rows_q[0] <= cfg_data_i;
        vmt_pkg::CFG_ROW_ONE:     rows_q[1] <= cfg_data_i;
        vmt_pkg::CFG_ROW_TWO:     rows_q[2] <= cfg_data_i;
        vmt_pkg::CFG_ROW_THREE:   rows_q[3] <= cfg_data_i;
        vmt_pkg::CFG_COLUMN_MODE: mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Column mode: lane i uses row i. Row mode: lane i uses column i.
  always_comb begin
    for (int l = 0; l < vmt_pkg::NUM_LANES; l++) begin
      for (int t = 0; t < vmt_pkg::NUM_LANES; t++) begin
        if (mode_q) begin
          lane_coef_o[l][t] = rows_q[l][t*vmt_pkg::COMP_W +: vmt_pkg::COMP_W];
        end else begin
          lane_coef_o[l][t] = rows_q[t][l*vmt_pkg::COMP_W +: vmt_pkg::COMP_W];
        end
      end
    end
  end

endmodule

@@ design/vmt_lane.sv @@
// One output lane: multiply stage, sum-and-round stage, saturate stage.
// Depends on vmt_pkg; advance is driven by the top-level stall control.
module vmt_lane (
  input  logic           clk_i,
  input  logic           en_i,
  input  vmt_pkg::quad_t vtx_i,
  input  vmt_pkg::quad_t coef_i,
  output vmt_pkg::comp_t res_o,
  output logic           sat_o
);

  vmt_pkg::prod_t prod_q [vmt_pkg::NUM_LANES];
  vmt_pkg::prod_t prod_d [vmt_pkg::NUM_LANES];
  vmt_pkg::sum_t  sum_q, sum_d;
  vmt_pkg::sum_t  shifted;
  vmt_pkg::comp_t res_q, res_d;
  logic           sat_q, sat_d;

  always_comb begin
    for (int t = 0; t < vmt_pkg::NUM_LANES; t++) begin
      prod_d[t] = $signed(vtx_i[t]) * $signed(coef_i[t]);
    end
  end

  always_comb begin
    sum_d = vmt_pkg::ROUND_BIAS;
    for (int t = 0; t < vmt_pkg::NUM_LANES; t++) begin
      sum_d = sum_d + vmt_pkg::sum_t'(prod_q[t]);
    end
  end

  always_comb begin
    shifted = sum_q >>> vmt_pkg::COEF_FRAC;
    if (shifted > vmt_pkg::SUM_LANE_MAX) begin
      res_d = vmt_pkg::comp_t'(vmt_pkg::SUM_LANE_MAX);
      sat_d = 1'b1;
    end else if (shifted < vmt_pkg::SUM_LANE_MIN) begin
      res_d = vmt_pkg::comp_t'(vmt_pkg::SUM_LANE_MIN);
      sat_d = 1'b1;
    end else begin
      res_d = shifted[vmt_pkg::COMP_W-1:0];
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int t = 0; t < vmt_pkg::NUM_LANES; t++) begin
        prod_q[t] <= prod_d[t];
      end
      sum_q <= sum_d;
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule
